>>> hw/rtl/tmw_pkg.sv
package tmw_pkg;

    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int COLSEL_W = 7;
    localparam int ROWSEL_W = 5;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;

    // Cursor math is done in these widths: one bit wider than the row and column selects
    localparam int ROWCALC_W = 6;
    localparam int COLCALC_W = 8;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam int                TAB_STOP     = 4;

    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT        = 3'd0,
        MODE_SET_CURSOR = 3'd1,
        MODE_CLR_SCREEN = 3'd2,
        MODE_CLR_ROW    = 3'd3,
        MODE_READ       = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_COPY,
        ST_COPY_LAST,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/tmw_if.sv
interface tmw_cmd_if import tmw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [CHAR_W-1:0]   char_code;
    logic [ATTR_W-1:0]   attribute;
    logic [COLSEL_W-1:0] col_sel;
    logic [ROWSEL_W-1:0] row_sel;

    modport source (output valid, mode, char_code, attribute, col_sel, row_sel,
                    input ready);
    modport sink   (input valid, mode, char_code, attribute, col_sel, row_sel,
                    output ready);
endinterface

interface tmw_res_if import tmw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] cursor_index;
    logic [CELL_W-1:0]  cell_data;

    modport source (output valid, cursor_index, cell_data, input ready);
    modport sink   (input valid, cursor_index, cell_data, output ready);
endinterface

>>> hw/rtl/tmw_cell_ram.sv
module tmw_cell_ram import tmw_pkg::*; #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/text_mode_terminal_writer.sv
// Text-mode terminal writer. Keeps a ROWS x COLUMNS screen of 16-bit cells
// (character in the low byte, attribute in the high byte) in one simple
// dual-port RAM, plus a cursor. Each command transfer on cmd produces exactly
// one transfer on res carrying the cursor index (row * COLUMNS + col, low 11
// bits) and, for an on-screen read-cell, the cell contents (zero otherwise).
// Put-char, set-cursor and ignored commands pass from accept through the
// done state into the result register; read-cell first passes a read state
// for the RAM read. Clear-row and clear-screen sweep the row or the whole
// screen, one cell write per cycle. A put-char that scrolls copies
// (ROWS-1)*COLUMNS cells through the RAM read/write ports, then blanks the
// bottom row. All of these are bounded by the single RAM write port. After
// reset a clearing pass writes 0x0720 into every cell (2000 by default),
// during which cmd.ready stays low. One command is worked on at a time; the
// next one is accepted while a finished result still waits on res.
module text_mode_terminal_writer import tmw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic     clk,
    input  logic     rst_n,
    tmw_cmd_if.sink  cmd,
    tmw_res_if.source res
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_ADDR      = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_START     = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_ROW_START = AW'((ROWS - 1) * COLUMNS);

    function automatic logic [AW-1:0] cell_addr(input logic [ROWCALC_W-1:0] r,
                                                input logic [COLCALC_W-1:0] c);
        return AW'(r * COLUMNS) + AW'(c);
    endfunction

    state_t state_reg, state_next;

    // cursor
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;

    // sweep pointers (fill and scroll copy)
    logic [AW-1:0] fill_addr_reg, fill_addr_next;
    logic [AW-1:0] fill_last_reg, fill_last_next;
    logic [AW-1:0] copy_addr_reg, copy_addr_next;
    logic          copy_pend_reg, copy_pend_next;
    logic [AW-1:0] copy_waddr_reg, copy_waddr_next;

    // command payload kept across the work
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic              rd_ok_reg, rd_ok_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [CELL_W-1:0]  out_data_reg, out_data_next;

    // RAM ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // put-char datapath
    logic [ROWCALC_W-1:0] cur_row, pc_row, wr_row, fin_row;
    logic [COLCALC_W-1:0] cur_col, pc_col, wr_col;
    logic                 pc_we;
    logic [AW-1:0]        pc_waddr;
    logic [CELL_W-1:0]    pc_wdata;
    logic                 pc_scroll;

    logic row_ok, col_ok;
    logic accept;
    logic out_free;

    tmw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_row = ROWCALC_W'(row_reg);
    assign cur_col = COLCALC_W'(col_reg);
    assign row_ok  = ROWCALC_W'(cmd.row_sel) < ROWCALC_W'(ROWS);
    assign col_ok  = COLCALC_W'(cmd.col_sel) < COLCALC_W'(COLUMNS);

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;

    // Character interpretation: cursor move, then line wrap, then scroll check
    always_comb
    begin
        pc_row   = cur_row;
        pc_col   = cur_col;
        pc_we    = 1'b0;
        pc_waddr = cell_addr(cur_row, cur_col);
        pc_wdata = {cmd.attribute, cmd.char_code};
        case (cmd.char_code)
            CH_NEWLINE:
            begin
                pc_col = '0;
                pc_row = cur_row + 1'b1;
            end
            CH_RETURN:
            begin
                pc_col = '0;
            end
            CH_TAB:
            begin
                pc_col = (cur_col + COLCALC_W'(TAB_STOP)) & ~COLCALC_W'(TAB_STOP - 1);
            end
            CH_BACKSPACE:
            begin
                if (cur_col != '0)
                begin
                    pc_col = cur_col - 1'b1;
                end
                else if (cur_row != '0)
                begin
                    pc_row = cur_row - 1'b1;
                    pc_col = COLCALC_W'(COLUMNS - 1);
                end
                pc_we    = 1'b1;
                pc_waddr = cell_addr(pc_row, pc_col);
                pc_wdata = {cmd.attribute, CH_SPACE};
            end
            default:
            begin
                pc_we  = 1'b1;
                pc_col = cur_col + 1'b1;
            end
        endcase

        wr_row = pc_row;
        wr_col = pc_col;
        if (pc_col >= COLCALC_W'(COLUMNS))
        begin
            wr_col = '0;
            wr_row = pc_row + 1'b1;
        end
        pc_scroll = wr_row >= ROWCALC_W'(ROWS);
        fin_row   = pc_scroll ? ROWCALC_W'(ROWS - 1) : wr_row;
    end

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        fill_addr_next  = fill_addr_reg;
        fill_last_next  = fill_last_reg;
        copy_addr_next  = copy_addr_reg;
        copy_pend_next  = copy_pend_reg;
        copy_waddr_next = copy_waddr_reg;
        attr_next       = attr_reg;
        data_next       = data_reg;
        rd_ok_next      = rd_ok_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_index_next  = out_index_reg;
        out_data_next   = out_data_reg;

        ram_we    = 1'b0;
        ram_waddr = fill_addr_reg;
        ram_wdata = {attr_reg, CH_SPACE};
        ram_raddr = copy_addr_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                // power-up blanking sweep
                ram_we         = 1'b1;
                ram_wdata      = CELL_RESET;
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    attr_next  = cmd.attribute;
                    data_next  = '0;
                    state_next = ST_DONE;
                    unique case (mode_t'(cmd.mode))
                        MODE_PUT:
                        begin
                            ram_we    = pc_we;
                            ram_waddr = pc_waddr;
                            ram_wdata = pc_wdata;
                            row_next  = RW'(fin_row);
                            col_next  = CW'(wr_col);
                            if (pc_scroll)
                            begin
                                copy_addr_next = COPY_START;
                                copy_pend_next = 1'b0;
                                state_next     = ST_COPY;
                            end
                        end
                        MODE_SET_CURSOR:
                        begin
                            if (row_ok && col_ok)
                            begin
                                row_next = RW'(cmd.row_sel);
                                col_next = CW'(cmd.col_sel);
                            end
                        end
                        MODE_CLR_SCREEN:
                        begin
                            row_next       = '0;
                            col_next       = '0;
                            fill_addr_next = '0;
                            fill_last_next = LAST_ADDR;
                            state_next     = ST_FILL;
                        end
                        MODE_CLR_ROW:
                        begin
                            if (row_ok)
                            begin
                                row_next       = RW'(cmd.row_sel);
                                col_next       = '0;
                                fill_addr_next = cell_addr(ROWCALC_W'(cmd.row_sel), '0);
                                fill_last_next = cell_addr(ROWCALC_W'(cmd.row_sel),
                                                           COLCALC_W'(COLUMNS - 1));
                                state_next     = ST_FILL;
                            end
                        end
                        MODE_READ:
                        begin
                            ram_raddr  = cell_addr(ROWCALC_W'(cmd.row_sel),
                                                   COLCALC_W'(cmd.col_sel));
                            rd_ok_next = row_ok && col_ok;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            // unused modes: no change
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                data_next  = rd_ok_reg ? ram_rdata : '0;
                state_next = ST_DONE;
            end
            ST_FILL:
            begin
                ram_we         = 1'b1;
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_reg == fill_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY:
            begin
                // read cell a, write it one row up on the next cycle
                ram_we          = copy_pend_reg;
                ram_waddr       = copy_waddr_reg;
                ram_wdata       = ram_rdata;
                copy_waddr_next = copy_addr_reg - COPY_START;
                copy_pend_next  = 1'b1;
                copy_addr_next  = copy_addr_reg + 1'b1;
                if (copy_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_COPY_LAST;
                end
            end
            ST_COPY_LAST:
            begin
                ram_we         = 1'b1;
                ram_waddr      = copy_waddr_reg;
                ram_wdata      = ram_rdata;
                copy_pend_next = 1'b0;
                fill_addr_next = LAST_ROW_START;
                fill_last_next = LAST_ADDR;
                state_next     = ST_FILL;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = INDEX_W'(row_reg * COLUMNS + col_reg);
                    out_data_next  = data_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            fill_addr_reg <= '0;
            copy_addr_reg <= '0;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            fill_addr_reg <= fill_addr_next;
            copy_addr_reg <= copy_addr_next;
            copy_pend_reg <= copy_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_last_reg  <= fill_last_next;
        copy_waddr_reg <= copy_waddr_next;
        attr_reg       <= attr_next;
        data_reg       <= data_next;
        rd_ok_reg      <= rd_ok_next;
        out_index_reg  <= out_index_next;
        out_data_reg   <= out_data_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.cursor_index = out_index_reg;
    assign res.cell_data    = out_data_reg;

endmodule

>>> hw/rtl/tmw_checker.sv
module tmw_checker import tmw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [INDEX_W-1:0] res_cursor_index,
    input logic [CELL_W-1:0]  res_cell_data
);

    localparam int CELLS = COLUMNS * ROWS;

    logic       cmd_xfer, res_xfer;
    logic [1:0] pend_reg, pend_next;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign res_xfer = res_valid && res_ready;

    always_comb
    begin
        pend_next = pend_reg + 2'(cmd_xfer) - 2'(res_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_cursor_index)
                                    && $stable(res_cell_data))
        else $error("result changed while stalled");

    // one command at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> !cmd_ready)
        else $error("command taken while busy");

    // at most one in work plus one waiting on res
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("too many commands outstanding");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 2'd0)
        else $error("result without a command");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> 32'(res_cursor_index) < CELLS)
        else $error("cursor index off screen");

endmodule

bind text_mode_terminal_writer tmw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmw_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_cursor_index (res.cursor_index),
    .res_cell_data    (res.cell_data)
);
